FILE: hdl/akd_pkg.sv
// Shared types, register codes and per-key debounce functions.
`timescale 1ns / 1ps
`default_nettype none

package akd_pkg;

    localparam int TIME_W = 7;
    localparam int ROW_W  = 3;
    localparam int BITS_W = 16;
    localparam int CFG_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_PRESS_LOCKOUT = 1'd0;
    localparam logic [CFG_W-1:0] CFG_RELEASE_DELAY = 1'd1;

    // One key timer: pending-press flag and remaining ms (0 = idle)
    typedef struct packed {
        logic              press;
        logic [TIME_W-1:0] cnt;
    } t_key;

    // Key timer together with the key's debounced bit
    typedef struct packed {
        t_key key;
        logic cooked;
    } t_key_res;

    // Zero acts as one
    function automatic logic [TIME_W-1:0] f_at_least_one(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    // Aging step of one key
    function automatic t_key_res f_age(input t_key k, input logic raw_b,
                                       input logic ck_b, input logic [TIME_W-1:0] el);
        t_key_res r;
        r.key    = k;
        r.cooked = ck_b;
        if (k.cnt != '0) begin
            if (k.cnt <= el) begin
                // deferred release commits the raw bit, a press only unlocks
                if (!k.press) begin
                    r.cooked = raw_b;
                end
                r.key.cnt = '0;
            end else begin
                r.key.cnt = k.cnt - el;
            end
        end
        return r;
    endfunction

    // Transition step of one key
    function automatic t_key_res f_trans(input t_key k, input logic raw_b,
                                         input logic ck_b,
                                         input logic [TIME_W-1:0] press_ms,
                                         input logic [TIME_W-1:0] rel_ms);
        t_key_res r;
        r.key    = k;
        r.cooked = ck_b;
        if (raw_b != ck_b) begin
            if (k.cnt == '0) begin
                if (raw_b) begin
                    // eager press: commit now, then lock out
                    r.cooked    = 1'b1;
                    r.key.press = 1'b1;
                    r.key.cnt   = press_ms;
                end else begin
                    r.key.press = 1'b0;
                    r.key.cnt   = rel_ms;
                end
            end
        end else if (k.cnt != '0 && !k.press) begin
            // raw bit came back: cancel pending release
            r.key = '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/akd_key_state.sv
// Per-row key timer and debounced bit storage, one row read and one row written a cycle.
`timescale 1ns / 1ps
`default_nettype none

module akd_key_state #(
    parameter int ROWS = 8,
    parameter int COLS = 16,
    parameter int RW   = 3
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [RW-1:0]               i_rd_row,
    output akd_pkg::t_key [COLS-1:0]         o_rd_timers,
    output logic [COLS-1:0]                  o_rd_cooked,
    input  wire logic                        i_wr_en,
    input  wire logic [RW-1:0]               i_wr_row,
    input  wire akd_pkg::t_key [COLS-1:0]    i_wr_timers,
    input  wire logic [COLS-1:0]             i_wr_cooked
);
    import akd_pkg::*;

    t_key [COLS-1:0] r_timers    [ROWS];
    logic [COLS-1:0] r_debounced [ROWS];

    // Row storage, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++) begin
                r_timers[r]    <= '0;
                r_debounced[r] <= '0;
            end
        end else if (i_wr_en) begin
            r_timers[i_wr_row]    <= i_wr_timers;
            r_debounced[i_wr_row] <= i_wr_cooked;
        end
    end

    assign o_rd_timers = r_timers[i_rd_row];
    assign o_rd_cooked = r_debounced[i_rd_row];

endmodule

`default_nettype wire

FILE: hdl/akd_age_stage.sv
// Aging stage: row read with bypass from the commit stage, per-column countdown aging.
`timescale 1ns / 1ps
`default_nettype none

module akd_age_stage #(
    parameter int ROWS = 8,
    parameter int COLS = 16,
    parameter int RW   = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic                          i_valid,
    input  wire logic [akd_pkg::ROW_W-1:0]     i_row,
    input  wire logic [COLS-1:0]               i_raw,
    input  wire logic [akd_pkg::TIME_W-1:0]    i_elapsed,
    // row read port
    output logic [RW-1:0]                      o_rd_row,
    input  wire akd_pkg::t_key [COLS-1:0]      i_rd_timers,
    input  wire logic [COLS-1:0]               i_rd_cooked,
    // bypass of the row the commit stage is producing
    input  wire logic                          i_fwd_en,
    input  wire logic [akd_pkg::ROW_W-1:0]     i_fwd_row,
    input  wire akd_pkg::t_key [COLS-1:0]      i_fwd_timers,
    input  wire logic [COLS-1:0]               i_fwd_cooked,
    // stage register
    output logic                               o_valid,
    output logic [akd_pkg::ROW_W-1:0]          o_row,
    output logic                               o_in_range,
    output logic [COLS-1:0]                    o_raw,
    output akd_pkg::t_key [COLS-1:0]           o_timers,
    output logic [COLS-1:0]                    o_cooked,
    output logic [COLS-1:0]                    o_before
);
    import akd_pkg::*;

    logic            in_range;
    logic            use_fwd;
    t_key [COLS-1:0] src_timers;
    logic [COLS-1:0] src_cooked;
    t_key [COLS-1:0] aged_timers;
    logic [COLS-1:0] aged_cooked;
    t_key_res        res [COLS];

    logic                  r_valid;
    logic [ROW_W-1:0]      r_row;
    logic                  r_in_range;
    logic [COLS-1:0]       r_raw;
    t_key [COLS-1:0]       r_timers;
    logic [COLS-1:0]       r_cooked;
    logic [COLS-1:0]       r_before;

    assign in_range = (32'(i_row) < ROWS);
    assign o_rd_row = RW'(i_row);

    // Take the newest copy of the row
    assign use_fwd    = i_fwd_en && (i_fwd_row == i_row);
    assign src_timers = use_fwd ? i_fwd_timers : i_rd_timers;
    assign src_cooked = use_fwd ? i_fwd_cooked : i_rd_cooked;

    // Per-column aging
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            res[c]         = f_age(src_timers[c], i_raw[c], src_cooked[c], i_elapsed);
            aged_timers[c] = res[c].key;
            aged_cooked[c] = res[c].cooked;
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row      <= i_row;
            r_in_range <= in_range;
            r_raw      <= i_raw;
            r_timers   <= aged_timers;
            r_cooked   <= aged_cooked;
            r_before   <= src_cooked;
        end
    end

    assign o_valid    = r_valid;
    assign o_row      = r_row;
    assign o_in_range = r_in_range;
    assign o_raw      = r_raw;
    assign o_timers   = r_timers;
    assign o_cooked   = r_cooked;
    assign o_before   = r_before;

endmodule

`default_nettype wire

FILE: hdl/akd_commit_stage.sv
// Commit stage: per-column transition step, row write-back and output register.
`timescale 1ns / 1ps
`default_nettype none

module akd_commit_stage #(
    parameter int COLS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [akd_pkg::TIME_W-1:0]    i_press_ms,
    input  wire logic [akd_pkg::TIME_W-1:0]    i_rel_ms,
    input  wire logic                          i_valid,
    input  wire logic [akd_pkg::ROW_W-1:0]     i_row,
    input  wire logic                          i_in_range,
    input  wire logic [COLS-1:0]               i_raw,
    input  wire akd_pkg::t_key [COLS-1:0]      i_timers,
    input  wire logic [COLS-1:0]               i_cooked,
    input  wire logic [COLS-1:0]               i_before,
    // next row state, for write-back and bypass
    output akd_pkg::t_key [COLS-1:0]           o_nx_timers,
    output logic [COLS-1:0]                    o_nx_cooked,
    // result register
    output logic                               o_valid,
    output logic [akd_pkg::ROW_W-1:0]          o_row,
    output logic [akd_pkg::BITS_W-1:0]         o_bits,
    output logic                               o_changed
);
    import akd_pkg::*;

    logic [TIME_W-1:0] press_eff;
    logic [TIME_W-1:0] rel_eff;
    t_key_res          res [COLS];
    t_key [COLS-1:0]   nx_timers;
    logic [COLS-1:0]   nx_cooked;

    logic              r_valid;
    logic [ROW_W-1:0]  r_row;
    logic [BITS_W-1:0] r_bits;
    logic              r_changed;

    assign press_eff = f_at_least_one(i_press_ms);
    assign rel_eff   = f_at_least_one(i_rel_ms);

    // Per-column transition
    always_comb begin
        for (int c = 0; c < COLS; c++) begin
            res[c]       = f_trans(i_timers[c], i_raw[c], i_cooked[c], press_eff, rel_eff);
            nx_timers[c] = res[c].key;
            nx_cooked[c] = res[c].cooked;
        end
    end

    assign o_nx_timers = nx_timers;
    assign o_nx_cooked = nx_cooked;

    // Result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Result payload; out-of-range rows report nothing pressed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_row     <= i_row;
            r_bits    <= i_in_range ? BITS_W'(nx_cooked) : '0;
            r_changed <= i_in_range && (nx_cooked != i_before);
        end
    end

    assign o_valid   = r_valid;
    assign o_row     = r_row;
    assign o_bits    = r_bits;
    assign o_changed = r_changed;

endmodule

`default_nettype wire

FILE: hdl/asym_eager_defer_key_debounce.sv
// Top level of the per-key eager-press / deferred-release matrix debouncer.
//
// Usage: each input transfer carries one raw scan word of a matrix row plus the
// milliseconds since that row was last scanned. Each input transfer yields
// exactly one output transfer with the debounced row and a changed flag.
// Both channels are valid/ready. Configuration is a plain write port
// (i_cfg_we, i_cfg_index, i_cfg_data): index 0 is the press lockout, index 1
// the release delay, both in ms, zero acting as one; other indexes are ignored.
// Path: a result passes the input register, the aging stage and the
// transition/output register in that order. Throughput: one row per cycle while
// the receiver keeps i_out_ready high, including back-to-back scans of the same row;
// the row state is written by the transition stage and bypassed to the aging stage.
// Stall: when the receiver holds i_out_ready low the result stays put and the
// stages behind it fill; o_in_ready drops only when all three stages are full.
// Reset (synchronous, active low) clears all timers, the debounced matrix,
// pipeline valids, and sets both times to 5 ms.
`timescale 1ns / 1ps
`default_nettype none

module asym_eager_defer_key_debounce #(
    parameter int ROWS = 8,
    parameter int COLS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [akd_pkg::CFG_W-1:0]     i_cfg_index,
    input  wire logic [akd_pkg::TIME_W-1:0]    i_cfg_data,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [akd_pkg::ROW_W-1:0]     i_row_index,
    input  wire logic [akd_pkg::BITS_W-1:0]    i_raw_bits,
    input  wire logic [akd_pkg::TIME_W-1:0]    i_elapsed_ms,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [akd_pkg::ROW_W-1:0]          o_out_row,
    output logic [akd_pkg::BITS_W-1:0]         o_cooked_bits,
    output logic                               o_row_changed
);
    import akd_pkg::*;

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Configuration registers
    logic [TIME_W-1:0] r_press_ms;
    logic [TIME_W-1:0] r_rel_ms;

    // Input register
    logic              r_s1_valid;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COLS-1:0]   r_s1_raw;
    logic [TIME_W-1:0] r_s1_elapsed;

    // Stage handshake
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s2_adv;

    // Aging stage outputs
    logic            s2_valid;
    logic [ROW_W-1:0] s2_row;
    logic            s2_in_range;
    logic [COLS-1:0] s2_raw;
    t_key [COLS-1:0] s2_timers;
    logic [COLS-1:0] s2_cooked;
    logic [COLS-1:0] s2_before;

    // Row storage ports
    logic [RW-1:0]   rd_row;
    t_key [COLS-1:0] rd_timers;
    logic [COLS-1:0] rd_cooked;
    t_key [COLS-1:0] nx_timers;
    logic [COLS-1:0] nx_cooked;
    logic            wr_en;
    logic            fwd_en;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ms <= TIME_W'(5);
            r_rel_ms   <= TIME_W'(5);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PRESS_LOCKOUT: r_press_ms <= i_cfg_data;
                CFG_RELEASE_DELAY: r_rel_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when its successor is empty or moving on
    assign out_free   = !o_out_valid || i_out_ready;
    assign s2_free    = !s2_valid || out_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign s2_adv     = s2_valid && out_free;
    assign o_in_ready = s1_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_row     <= i_row_index;
            r_s1_raw     <= COLS'(i_raw_bits);
            r_s1_elapsed <= i_elapsed_ms;
        end
    end

    // Write-back when the commit stage hands its row to the output register
    assign wr_en  = s2_adv && s2_in_range;
    assign fwd_en = s2_valid && s2_in_range;

    akd_key_state #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW)
    ) u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_row    (rd_row),
        .o_rd_timers (rd_timers),
        .o_rd_cooked (rd_cooked),
        .i_wr_en     (wr_en),
        .i_wr_row    (RW'(s2_row)),
        .i_wr_timers (nx_timers),
        .i_wr_cooked (nx_cooked)
    );

    akd_age_stage #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW)
    ) u_age (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (s2_free),
        .i_valid      (r_s1_valid),
        .i_row        (r_s1_row),
        .i_raw        (r_s1_raw),
        .i_elapsed    (r_s1_elapsed),
        .o_rd_row     (rd_row),
        .i_rd_timers  (rd_timers),
        .i_rd_cooked  (rd_cooked),
        .i_fwd_en     (fwd_en),
        .i_fwd_row    (s2_row),
        .i_fwd_timers (nx_timers),
        .i_fwd_cooked (nx_cooked),
        .o_valid      (s2_valid),
        .o_row        (s2_row),
        .o_in_range   (s2_in_range),
        .o_raw        (s2_raw),
        .o_timers     (s2_timers),
        .o_cooked     (s2_cooked),
        .o_before     (s2_before)
    );

    akd_commit_stage #(
        .COLS (COLS)
    ) u_commit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_free),
        .i_press_ms  (r_press_ms),
        .i_rel_ms    (r_rel_ms),
        .i_valid     (s2_valid),
        .i_row       (s2_row),
        .i_in_range  (s2_in_range),
        .i_raw       (s2_raw),
        .i_timers    (s2_timers),
        .i_cooked    (s2_cooked),
        .i_before    (s2_before),
        .o_nx_timers (nx_timers),
        .o_nx_cooked (nx_cooked),
        .o_valid     (o_out_valid),
        .o_row       (o_out_row),
        .o_bits      (o_cooked_bits),
        .o_changed   (o_row_changed)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the eager-press / deferred-release matrix debouncer.
`timescale 1ns / 1ps

module tb;

    import akd_pkg::*;

    localparam int N_ROWS = 8;
    localparam int N_COLS = 16;

    // One debounced row as the block reports it
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [BITS_W-1:0] bits;
        logic              changed;
    } t_debounced_row;

    // Directed steps: a row scan or a register write
    typedef enum logic { STEP_SCAN, STEP_CFG } t_step_kind;

    // For a register write, idx is the register and el carries the value
    typedef struct {
        t_step_kind        kind;
        logic [ROW_W-1:0]  idx;
        logic [BITS_W-1:0] bits;
        logic [TIME_W-1:0] el;
        bit                typed;
        logic [BITS_W-1:0] exp_bits;
        bit                exp_chg;
    } t_dir_step;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [ROW_W-1:0] i_row_index = '0;
    logic [BITS_W-1:0] i_raw_bits = '0;
    logic [TIME_W-1:0] i_elapsed_ms = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [ROW_W-1:0] o_out_row;
    logic [BITS_W-1:0] o_cooked_bits;
    logic o_row_changed;

    // Predictor state: per-key timers, debounced rows, configured times
    t_key key_tmr [N_ROWS][N_COLS];
    logic [BITS_W-1:0] db_rows [N_ROWS];
    logic [TIME_W-1:0] lock_ms;
    logic [TIME_W-1:0] rel_ms;

    t_debounced_row pending_rows[$];
    int mismatch_cnt = 0;
    bit calm = 1'b0;
    logic [BITS_W-1:0] phys [N_ROWS];

    // Directed stimulus; typed results follow straight from the timing rules
    t_dir_step dir_steps [0:25] = '{
        // after reset nothing is pressed
        '{STEP_SCAN, 3'd0, 16'h0000, 7'd0,   1'b1, 16'h0000, 1'b0},
        // eager press of the whole row
        '{STEP_SCAN, 3'd0, 16'hFFFF, 7'd0,   1'b1, 16'hFFFF, 1'b1},
        // release during lockout is ignored
        '{STEP_SCAN, 3'd0, 16'h0000, 7'd0,   1'b1, 16'hFFFF, 1'b0},
        // lockout ends, deferred release starts
        '{STEP_SCAN, 3'd0, 16'h0000, 7'd127, 1'b1, 16'hFFFF, 1'b0},
        // raw bit returns: release cancelled
        '{STEP_SCAN, 3'd0, 16'hFFFF, 7'd1,   1'b1, 16'hFFFF, 1'b0},
        '{STEP_SCAN, 3'd0, 16'h0000, 7'd0,   1'b1, 16'hFFFF, 1'b0},
        // release delay elapses exactly
        '{STEP_SCAN, 3'd0, 16'h0000, 7'd5,   1'b1, 16'h0000, 1'b1},
        '{STEP_SCAN, 3'd7, 16'h8001, 7'd0,   1'b1, 16'h8001, 1'b1},
        '{STEP_SCAN, 3'd7, 16'h8001, 7'd127, 1'b1, 16'h8001, 1'b0},
        '{STEP_SCAN, 3'd3, 16'hAAAA, 7'd3,   1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd3, 16'h5555, 7'd2,   1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd3, 16'h5555, 7'd4,   1'b0, 16'h0000, 1'b0},
        // zero lockout acts as one, longest release delay
        '{STEP_CFG,  ROW_W'(CFG_PRESS_LOCKOUT), 16'h0, 7'd0,   1'b0, 16'h0, 1'b0},
        '{STEP_CFG,  ROW_W'(CFG_RELEASE_DELAY), 16'h0, 7'd127, 1'b0, 16'h0, 1'b0},
        '{STEP_SCAN, 3'd1, 16'h00FF, 7'd0,   1'b1, 16'h00FF, 1'b1},
        '{STEP_SCAN, 3'd1, 16'h0000, 7'd1,   1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd1, 16'h0000, 7'd126, 1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd1, 16'h0000, 7'd1,   1'b0, 16'h0000, 1'b0},
        // longest lockout, zero release delay acts as one
        '{STEP_CFG,  ROW_W'(CFG_PRESS_LOCKOUT), 16'h0, 7'd127, 1'b0, 16'h0, 1'b0},
        '{STEP_CFG,  ROW_W'(CFG_RELEASE_DELAY), 16'h0, 7'd0,   1'b0, 16'h0, 1'b0},
        '{STEP_SCAN, 3'd2, 16'hF0F0, 7'd0,   1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd2, 16'h0000, 7'd126, 1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd2, 16'h0000, 7'd1,   1'b0, 16'h0000, 1'b0},
        '{STEP_SCAN, 3'd2, 16'h0000, 7'd1,   1'b0, 16'h0000, 1'b0},
        '{STEP_CFG,  ROW_W'(CFG_PRESS_LOCKOUT), 16'h0, 7'd5, 1'b0, 16'h0, 1'b0},
        '{STEP_CFG,  ROW_W'(CFG_RELEASE_DELAY), 16'h0, 7'd5, 1'b0, 16'h0, 1'b0}
    };

    asym_eager_defer_key_debounce DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_row_index   (i_row_index),
        .i_raw_bits    (i_raw_bits),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_row     (o_out_row),
        .o_cooked_bits (o_cooked_bits),
        .o_row_changed (o_row_changed)
    );

    always #10 i_clk = ~i_clk;

    // Debounce one row scan: age the countdowns, then look for new transitions
    function automatic t_debounced_row scan_row(input logic [ROW_W-1:0] row,
                                                input logic [BITS_W-1:0] raw,
                                                input logic [TIME_W-1:0] el);
        t_key k;
        logic [BITS_W-1:0] ck;
        t_debounced_row r;
        ck = db_rows[row];
        for (int c = 0; c < N_COLS; c++) begin
            k = key_tmr[row][c];
            if (k.cnt != '0) begin
                if (k.cnt <= el) begin
                    if (!k.press) ck[c] = raw[c];
                    k.cnt = '0;
                end else begin
                    k.cnt = k.cnt - el;
                end
            end
            key_tmr[row][c] = k;
        end
        for (int c = 0; c < N_COLS; c++) begin
            k = key_tmr[row][c];
            if (raw[c] != ck[c]) begin
                if (k.cnt == '0) begin
                    if (raw[c]) begin
                        ck[c] = 1'b1;
                        k.press = 1'b1;
                        k.cnt = (lock_ms == '0) ? TIME_W'(1) : lock_ms;
                    end else begin
                        k.press = 1'b0;
                        k.cnt = (rel_ms == '0) ? TIME_W'(1) : rel_ms;
                    end
                end
            end else if (k.cnt != '0 && !k.press) begin
                k = '0;
            end
            key_tmr[row][c] = k;
        end
        r.row = row;
        r.bits = ck;
        r.changed = (ck != db_rows[row]);
        db_rows[row] = ck;
        return r;
    endfunction

    // Present one scan word and wait for its transfer
    task automatic send_scan(input logic [ROW_W-1:0] row, input logic [BITS_W-1:0] raw,
                             input logic [TIME_W-1:0] el, input bit typed,
                             input logic [BITS_W-1:0] exp_bits, input bit exp_chg);
        t_debounced_row r;
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_row_index <= row;
        i_raw_bits <= raw;
        i_elapsed_ms <= el;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = scan_row(row, raw, el);
        if (typed) begin
            r.bits = exp_bits;
            r.changed = exp_chg;
        end
        pending_rows.push_back(r);
    endtask

    // Drain the pipeline before touching a register
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [TIME_W-1:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_PRESS_LOCKOUT) lock_ms = val;
        else if (idx == CFG_RELEASE_DELAY) rel_ms = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly short times so countdowns expire, with both extremes mixed in
    function automatic logic [TIME_W-1:0] pick_ms();
        case ($urandom_range(3))
            0: return '0;
            1: return 7'd127;
            default: return TIME_W'($urandom_range(1, 12));
        endcase
    endfunction

    // Receiver side stalls
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 15);
    end

    // Compare every output transfer against the oldest expected row
    always @(posedge i_clk) begin
        t_debounced_row e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rows.size() == 0) begin
                mismatch_cnt++;
                $display("%0t: unexpected row %0d bits %h changed %b", $time,
                         o_out_row, o_cooked_bits, o_row_changed);
            end else begin
                e = pending_rows.pop_front();
                if (o_out_row !== e.row) begin
                    mismatch_cnt++;
                    $display("%0t: out_row expected %0d actual %0d", $time, e.row, o_out_row);
                end
                if (o_cooked_bits !== e.bits) begin
                    mismatch_cnt++;
                    $display("%0t: cooked_bits row %0d expected %h actual %h", $time,
                             e.row, e.bits, o_cooked_bits);
                end
                if (o_row_changed !== e.changed) begin
                    mismatch_cnt++;
                    $display("%0t: row_changed row %0d expected %b actual %b", $time,
                             e.row, e.changed, o_row_changed);
                end
            end
        end
    end

    // Main sequence
    initial begin
        logic [ROW_W-1:0] row;
        logic [BITS_W-1:0] raw;
        logic [TIME_W-1:0] el;
        for (int r = 0; r < N_ROWS; r++) begin
            db_rows[r] = '0;
            phys[r] = '0;
            for (int c = 0; c < N_COLS; c++) key_tmr[r][c] = '0;
        end
        lock_ms = 7'd5;
        rel_ms = 7'd5;
        row = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        foreach (dir_steps[i]) begin
            if (dir_steps[i].kind == STEP_CFG)
                write_reg(dir_steps[i].idx[CFG_W-1:0], dir_steps[i].el);
            else
                send_scan(dir_steps[i].idx, dir_steps[i].bits, dir_steps[i].el,
                          dir_steps[i].typed, dir_steps[i].exp_bits, dir_steps[i].exp_chg);
        end

        // random part: mostly bouncing keys per row, some raw noise
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_PRESS_LOCKOUT, pick_ms());
            write_reg(CFG_RELEASE_DELAY, pick_ms());
            calm = (ph == 1);
            for (int n = 0; n < 233; n++) begin
                if ($urandom_range(99) >= 30) row = ROW_W'($urandom_range(N_ROWS - 1));
                if ($urandom_range(99) < 80) begin
                    if ($urandom_range(3) == 0)
                        phys[row] = phys[row] ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
                    raw = phys[row];
                    if ($urandom_range(2) == 0)
                        raw = raw ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
                    el = ($urandom_range(9) == 0) ? TIME_W'($urandom_range(127))
                                                  : TIME_W'($urandom_range(6));
                end else begin
                    raw = 16'($urandom);
                    el = TIME_W'($urandom_range(127));
                end
                send_scan(row, raw, el, 1'b0, '0, 1'b0);
            end
            calm = 1'b0;
        end

        // drain and let the pipeline settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_rows.size() == 0) begin
            $display("** asym_eager_defer_key_debounce: PASSED **");
        end else begin
            $display("** asym_eager_defer_key_debounce: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #5000000;
        $display("** asym_eager_defer_key_debounce: FAILED **");
        $finish;
    end

endmodule
